// ----- rtl/msq_pkg.sv -----
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants of the motion segment queue
// Holds the item and result structs, the operation and status codes, the
// controller states and the queue sizing constants.
// ----------------------------------------------------------------------------
package msq_pkg;

    // Number of queue slots; one slot always stays free, so the queue holds
    // QUEUE_DEPTH-1 segments at most.
    localparam int unsigned QUEUE_DEPTH = 32;
    localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // The rate quotient is produced one bit per cycle.
    localparam int unsigned DIV_BITS = 32;
    localparam int unsigned CNT_W    = $clog2(DIV_BITS);

    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_FLUSH = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_MAX,
        S_DIV,
        S_WRITE,
        S_POP
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] move_x;
        logic signed [31:0] move_y;
        logic signed [31:0] move_z;
        logic [31:0]        duration_us;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] out_steps_x;
        logic [30:0] out_steps_y;
        logic [30:0] out_steps_z;
        logic [30:0] out_max_steps;
        logic [31:0] out_rate;
    } t_result;

    // One stored segment.
    typedef struct packed {
        logic [30:0] steps_x;
        logic [30:0] steps_y;
        logic [30:0] steps_z;
        logic [30:0] max_steps;
        logic [31:0] rate;
    } t_entry;

    // Absolute value of a signed step count, saturated to 31 bits.
    function automatic logic [30:0] magnitude31(input logic [31:0] v);
        logic [31:0] neg;
        logic [30:0] m;
        begin
            neg = 32'd0 - v;
            if (v == 32'h8000_0000) begin
                m = 31'h7FFF_FFFF;
            end else if (v[31]) begin
                m = neg[30:0];
            end else begin
                m = v[30:0];
            end
            return m;
        end
    endfunction

endpackage

// ----- rtl/motion_segment_queue.sv -----
// ----------------------------------------------------------------------------
// motion_segment_queue: ring queue of linear move segments
// Stores absolute step counts, their maximum and the microseconds-per-step
// rate of each pushed move, and hands them back oldest first.
// ----------------------------------------------------------------------------
// Usage. An item is taken at a rising edge where i_start is high and o_busy
// is low; i_item carries the operation and the move fields. Every item gives
// exactly one result on o_result, marked by o_done for one cycle. The
// receiver cannot hold results off, so nothing waits on the output side.
//
// Timing. A flush, an unused operation code, a push into a full queue and a
// pop of an empty queue finish with o_done in the cycle after acceptance. A
// pop of a stored segment passes through the pop state, since the segment
// memory has a registered read port. A zero-length push ends after the
// magnitude and maximum states; a stored push goes on to the rate
// quotient, which a restoring divider produces one bit per cycle, and then
// writes the memory. That divider sets the rate of pushes. A new item may
// be accepted in the cycle in which o_done is high.
//
// Reset. A synchronous low i_rst_n empties the queue by clearing both
// pointers and returns the controller to idle. The segment memory itself
// is not cleared: only written slots are ever read back.
// ----------------------------------------------------------------------------
module motion_segment_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  msq_pkg::t_item    i_item,
    output logic              o_busy,
    output logic              o_done,
    output msq_pkg::t_result  o_result
);

    // Controller state.
    msq_pkg::t_state r_state;
    msq_pkg::t_state n_state;

    // Queue pointers.
    logic [msq_pkg::PTR_W-1:0] r_wr_ptr;
    logic [msq_pkg::PTR_W-1:0] r_rd_ptr;
    logic [msq_pkg::PTR_W-1:0] wr_ptr_inc;
    logic [msq_pkg::PTR_W-1:0] rd_ptr_inc;
    logic                      q_full;
    logic                      q_empty;

    // Captured push operands and intermediate results.
    logic [31:0] r_raw_x;
    logic [31:0] r_raw_y;
    logic [31:0] r_raw_z;
    logic [30:0] r_ax;
    logic [30:0] r_ay;
    logic [30:0] r_az;
    logic [30:0] r_mx;
    logic [30:0] max_xyz;

    // Bit-serial divider: the dividend shifts out of the top of r_quot while
    // quotient bits shift in at the bottom.
    logic [31:0]               r_quot;
    logic [30:0]               r_rem;
    logic [msq_pkg::CNT_W-1:0] r_cnt;
    logic [31:0]               div_trial;
    logic                      div_ge;
    logic [31:0]               div_diff;

    // Segment memory.
    msq_pkg::t_entry r_mem [msq_pkg::QUEUE_DEPTH];
    msq_pkg::t_entry r_rd_data;
    msq_pkg::t_entry wr_entry;
    logic            mem_we;

    // Result register.
    logic             r_done;
    logic             n_done;
    msq_pkg::t_result r_result;
    msq_pkg::t_result init_result;

    logic accept;

    assign accept = i_start && (r_state == msq_pkg::S_IDLE);

    // Pointer arithmetic, written so that any queue depth works.
    assign wr_ptr_inc = (r_wr_ptr == msq_pkg::PTR_W'(msq_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_wr_ptr + 1'b1;
    assign rd_ptr_inc = (r_rd_ptr == msq_pkg::PTR_W'(msq_pkg::QUEUE_DEPTH - 1))
                        ? '0 : r_rd_ptr + 1'b1;
    assign q_full  = (wr_ptr_inc == r_rd_ptr);
    assign q_empty = (r_wr_ptr == r_rd_ptr);

    // Largest of the three magnitudes.
    always_comb begin
        max_xyz = r_ax;
        if (r_ay > max_xyz) begin
            max_xyz = r_ay;
        end
        if (r_az > max_xyz) begin
            max_xyz = r_az;
        end
    end

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor when it fits. The remainder stays below the
    // divisor, so it always fits in 31 bits.
    assign div_trial = {r_rem, r_quot[31]};
    assign div_ge    = (div_trial >= {1'b0, r_mx});
    assign div_diff  = div_trial - {1'b0, r_mx};

    assign wr_entry = '{steps_x:   r_ax,
                        steps_y:   r_ay,
                        steps_z:   r_az,
                        max_steps: r_mx,
                        rate:      r_quot};

    // Result loaded when an item is taken: all data fields cleared and the
    // status of the operations that finish at once already in place.
    always_comb begin
        init_result = '0;
        if (i_item.func == msq_pkg::FN_PUSH && q_full) begin
            init_result.status = msq_pkg::ST_FULL;
        end else if (i_item.func == msq_pkg::FN_POP && q_empty) begin
            init_result.status = msq_pkg::ST_EMPTY;
        end else begin
            init_result.status = msq_pkg::ST_OK;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msq_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_item.func == msq_pkg::FN_PUSH && !q_full) begin
                        n_state = msq_pkg::S_ABS;
                    end else if (i_item.func == msq_pkg::FN_POP && !q_empty) begin
                        n_state = msq_pkg::S_POP;
                    end
                end
            end
            msq_pkg::S_ABS: begin
                n_state = msq_pkg::S_MAX;
            end
            msq_pkg::S_MAX: begin
                n_state = (max_xyz == '0) ? msq_pkg::S_IDLE : msq_pkg::S_DIV;
            end
            msq_pkg::S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = msq_pkg::S_WRITE;
                end
            end
            msq_pkg::S_WRITE: begin
                n_state = msq_pkg::S_IDLE;
            end
            msq_pkg::S_POP: begin
                n_state = msq_pkg::S_IDLE;
            end
            default: begin
                n_state = msq_pkg::S_IDLE;
            end
        endcase
    end

    // Output and strobe logic of the controller.
    always_comb begin
        o_busy = 1'b1;
        mem_we = 1'b0;
        unique case (r_state)
            msq_pkg::S_IDLE:  o_busy = 1'b0;
            msq_pkg::S_WRITE: mem_we = 1'b1;
            default:          mem_we = 1'b0;
        endcase
    end

    // The result strobe rises in the cycle after the last step of an item.
    always_comb begin
        n_done = 1'b0;
        if (accept) begin
            unique case (msq_pkg::t_func'(i_item.func))
                msq_pkg::FN_PUSH:  n_done = q_full;
                msq_pkg::FN_POP:   n_done = q_empty;
                msq_pkg::FN_FLUSH: n_done = 1'b1;
                msq_pkg::FN_NONE:  n_done = 1'b1;
            endcase
        end
        if (r_state == msq_pkg::S_MAX && max_xyz == '0) begin
            n_done = 1'b1;
        end
        if (r_state == msq_pkg::S_WRITE || r_state == msq_pkg::S_POP) begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msq_pkg::S_IDLE;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (accept && i_item.func == msq_pkg::FN_FLUSH) begin
                r_rd_ptr <= r_wr_ptr;
            end
            if (r_state == msq_pkg::S_WRITE) begin
                r_wr_ptr <= wr_ptr_inc;
            end
            if (r_state == msq_pkg::S_POP) begin
                r_rd_ptr <= rd_ptr_inc;
            end
        end
    end

    // Datapath and result registers; these need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw_x  <= i_item.move_x;
            r_raw_y  <= i_item.move_y;
            r_raw_z  <= i_item.move_z;
            r_quot   <= i_item.duration_us;
            r_result <= init_result;
        end
        if (r_state == msq_pkg::S_ABS) begin
            r_ax <= msq_pkg::magnitude31(r_raw_x);
            r_ay <= msq_pkg::magnitude31(r_raw_y);
            r_az <= msq_pkg::magnitude31(r_raw_z);
        end
        if (r_state == msq_pkg::S_MAX) begin
            r_mx  <= max_xyz;
            r_rem <= '0;
            r_cnt <= msq_pkg::CNT_W'(msq_pkg::DIV_BITS - 1);
            if (max_xyz == '0) begin
                r_result.status <= msq_pkg::ST_ZERO;
            end
        end
        if (r_state == msq_pkg::S_DIV) begin
            r_rem  <= div_ge ? div_diff[30:0] : div_trial[30:0];
            r_quot <= {r_quot[30:0], div_ge};
            r_cnt  <= r_cnt - 1'b1;
        end
        if (r_state == msq_pkg::S_POP) begin
            r_result.status        <= msq_pkg::ST_OK;
            r_result.out_steps_x   <= r_rd_data.steps_x;
            r_result.out_steps_y   <= r_rd_data.steps_y;
            r_result.out_steps_z   <= r_rd_data.steps_z;
            r_result.out_max_steps <= r_rd_data.max_steps;
            r_result.out_rate      <= r_rd_data.rate;
        end
    end

    // Segment memory with one write port and one registered read port. The
    // read address is the read pointer, so the oldest segment is ready in the
    // cycle after a pop is accepted.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= wr_entry;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A result only appears once the controller is back in idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while the controller is busy");

    // Every accepted item either keeps the block busy or finishes at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted item neither started nor finished");

    // Only a successful pop carries segment data.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != msq_pkg::ST_OK) |->
        (o_result.out_steps_x == '0 && o_result.out_steps_y == '0 &&
         o_result.out_steps_z == '0 && o_result.out_max_steps == '0 &&
         o_result.out_rate == '0))
        else $error("segment data on a result that is not a pop");

    // A stored segment always has a nonzero maximum and never goes into a full queue.
    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_mx != '0 && !q_full))
        else $error("zero-length segment or write into a full queue");

endmodule
